// ===== rtl/sfam_pkg.sv =====
// Shared types and constants for the sensor frame alarm monitor.
`timescale 1ns / 1ps

package sfam_pkg;

  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0] TYPE_PRESENCE = 8'd7;
  localparam logic [7:0] TYPE_CLIMATE  = 8'd10;
  localparam logic [7:0] TYPE_SMOKE    = 8'd11;
  localparam logic [7:0] DETECT_FLAG   = 8'h01;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;

  localparam logic [15:0] HUM_HIGH_RST  = 16'd650;
  localparam logic [15:0] HUM_LOW_RST   = 16'd300;
  localparam logic [15:0] TEMP_HIGH_RST = 16'd380;
  localparam logic [15:0] TEMP_LOW_RST  = 16'd0;
  localparam logic [7:0]  SILENCE_RST   = 8'd20;

  typedef enum logic [1:0] {
    KIND_PRESENCE = 2'd0,
    KIND_CLIMATE  = 2'd1,
    KIND_SMOKE    = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ALERT_NONE = 2'd0,
    ALERT_HIGH = 2'd1,
    ALERT_LOW  = 2'd2
  } alert_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUM_HIGH  = 3'd0,
    CFG_HUM_LOW   = 3'd1,
    CFG_TEMP_HIGH = 3'd2,
    CFG_TEMP_LOW  = 3'd3,
    CFG_SILENCE   = 3'd4,
    CFG_GUARD     = 3'd5
  } cfg_idx_t;

  // latch index of the armed_r store
  localparam int unsigned ARM_INTRUDER = 0;
  localparam int unsigned ARM_HUMIDITY = 1;
  localparam int unsigned ARM_TEMP     = 2;

  typedef struct packed {
    logic [7:0]  net_flag;
    logic [31:0] node_address;
    logic [31:0] root_address;
    logic [7:0]  node_state;
    logic [7:0]  channel;
    logic [7:0]  port_number;
    logic [7:0]  sensor_type;
    logic [7:0]  sensor_index;
    logic [7:0]  command_seq;
    logic [47:0] payload;
  } frame_t;

  typedef struct packed {
    logic [1:0]  sensor_kind;
    logic        detected;
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
    logic [1:0]  humidity_alert;
    logic [1:0]  temperature_alert;
    logic        intruder_alert;
    logic        log_record;
    logic        climate_silent;
    logic        presence_silent;
    logic        smoke_silent;
  } result_t;

  typedef struct packed {
    cfg_idx_t                index;
    logic [CFG_DATA_W-1:0]   wdata;
  } cfg_wr_t;

endpackage

// ===== rtl/sfam_if.sv =====
// Handshake channel interfaces for frames, results and register writes.
`timescale 1ns / 1ps

interface sfam_frame_if;
  logic              valid;
  logic              ready;
  sfam_pkg::frame_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfam_result_if;
  logic              valid;
  logic              ready;
  sfam_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfam_cfg_if;
  logic              valid;
  logic              ready;
  sfam_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sensor_frame_alarm_monitor_top.sv =====
// Sensor frame alarm monitor: classify frames, track silence, fire alerts, flag changes.
`timescale 1ns / 1ps

// Usage:
//   in_bus  : one decoded radio frame per beat (valid/ready).
//   out_bus : one result per frame, in order (valid/ready).
//   cfg_bus : register writes, index 0..5 as humidity high/low, temperature
//             high/low, silence limit, guard mode; other indexes are dropped.
//             Always ready; write only while no frame is in flight.
// Timing: a frame lands in the input register on the beat, and its result is
//   registered in the output register when the update stage advances.
//   Throughput is one frame per cycle while out_ready is high, set by the single
//   update stage between the input register and the result register, where all
//   per-class counters, latches and stored frames are updated together.
// Stall: while out_ready is low the result holds; one more frame may wait in
//   the input register, then in_ready drops.
// Reset (rst_n low, synchronous): registers return to their reset limits,
//   counters clear, every class is marked first-frame and every alert latch
//   re-arms. Stored previous frames are not cleared; a class's first frame
//   overwrites them before they are compared.
module sensor_frame_alarm_monitor_top (
  input  logic           clk,
  input  logic           rst_n,
  sfam_frame_if.sink     in_bus,
  sfam_result_if.source  out_bus,
  sfam_cfg_if.sink       cfg_bus
);
  import sfam_pkg::*;

  // configuration registers
  logic [15:0] hum_high_r, hum_low_r, temp_high_r, temp_low_r;
  logic [7:0]  silence_r;
  logic        guard_r;

  // pipeline
  logic    s1_valid_r;
  frame_t  s1_data_r;
  logic    out_valid_r;
  result_t out_data_r;
  logic    advance;
  logic    move;

  // per-class state
  logic [7:0]  cnt_r     [NUM_CLASSES];
  logic [7:0]  cnt_nxt   [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] first_r, first_nxt;
  logic [NUM_CLASSES-1:0] armed_r, armed_nxt;
  logic [63:0] prev_addr_r [NUM_CLASSES];
  logic [55:0] prev_ctrl_r [NUM_CLASSES];
  logic [47:0] prev_pay_r  [NUM_CLASSES];

  // update logic signals
  result_t     res_nxt;
  kind_t       kind;
  logic [1:0]  kidx;
  logic        known;
  logic        det;
  logic [15:0] hum, temp;
  logic [63:0] cur_addr;
  logic [55:0] cur_ctrl;
  logic [NUM_CLASSES-1:0] silent;
  alert_t      hum_code, temp_code;

  assign advance       = !out_valid_r || out_bus.ready;
  assign move          = s1_valid_r && advance;
  assign in_bus.ready  = !s1_valid_r || advance;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_high_r  <= HUM_HIGH_RST;
      hum_low_r   <= HUM_LOW_RST;
      temp_high_r <= TEMP_HIGH_RST;
      temp_low_r  <= TEMP_LOW_RST;
      silence_r   <= SILENCE_RST;
      guard_r     <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.data.index)
        CFG_HUM_HIGH:  hum_high_r  <= cfg_bus.data.wdata;
        CFG_HUM_LOW:   hum_low_r   <= cfg_bus.data.wdata;
        CFG_TEMP_HIGH: temp_high_r <= cfg_bus.data.wdata;
        CFG_TEMP_LOW:  temp_low_r  <= cfg_bus.data.wdata;
        CFG_SILENCE:   silence_r   <= cfg_bus.data.wdata[7:0];
        CFG_GUARD:     guard_r     <= cfg_bus.data.wdata[0];
        default: ;
      endcase
    end
  end

  function automatic alert_t level_code(input logic [15:0] v, input logic [15:0] hi,
                                        input logic [15:0] lo);
    alert_t c;
    c = ALERT_NONE;
    if (v > hi) begin
      c = ALERT_HIGH;
    end else if (v < lo) begin
      c = ALERT_LOW;
    end
    return c;
  endfunction

  always_comb begin
    case (s1_data_r.sensor_type)
      TYPE_PRESENCE: kind = KIND_PRESENCE;
      TYPE_CLIMATE:  kind = KIND_CLIMATE;
      TYPE_SMOKE:    kind = KIND_SMOKE;
      default:       kind = KIND_UNKNOWN;
    endcase
  end

  assign kidx      = kind;
  assign known     = (kind != KIND_UNKNOWN);
  assign det       = (s1_data_r.payload[7:0] == DETECT_FLAG);
  assign hum       = s1_data_r.payload[31:16];
  assign temp      = s1_data_r.payload[15:0];
  assign cur_addr  = {s1_data_r.node_address, s1_data_r.root_address};
  assign cur_ctrl  = {s1_data_r.net_flag, s1_data_r.node_state, s1_data_r.channel,
                      s1_data_r.port_number, s1_data_r.sensor_type,
                      s1_data_r.sensor_index, s1_data_r.command_seq};
  assign hum_code  = level_code(hum, hum_high_r, hum_low_r);
  assign temp_code = level_code(temp, temp_high_r, temp_low_r);

  always_comb begin
    res_nxt   = '0;
    first_nxt = first_r;
    armed_nxt = armed_r;

    // saturating count, silent test after increment, own class clears
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cnt_nxt[i] = (cnt_r[i] == COUNT_MAX) ? COUNT_MAX : cnt_r[i] + 8'd1;
      silent[i]  = (cnt_nxt[i] > silence_r);
      if (known && (kidx == i[1:0])) begin
        cnt_nxt[i] = '0;
      end
    end

    res_nxt.sensor_kind     = kind;
    res_nxt.climate_silent  = silent[KIND_CLIMATE];
    res_nxt.presence_silent = silent[KIND_PRESENCE];
    res_nxt.smoke_silent    = silent[KIND_SMOKE];

    case (kind)
      KIND_PRESENCE: begin
        res_nxt.detected = det;
        if (det) begin
          if (guard_r && armed_r[ARM_INTRUDER]) begin
            res_nxt.intruder_alert  = 1'b1;
            armed_nxt[ARM_INTRUDER] = 1'b0;
          end
        end else begin
          armed_nxt[ARM_INTRUDER] = 1'b1;
        end
      end
      KIND_CLIMATE: begin
        res_nxt.humidity_tenths    = hum;
        res_nxt.temperature_tenths = temp;
        if (hum_code == ALERT_NONE) begin
          armed_nxt[ARM_HUMIDITY] = 1'b1;
        end else if (armed_r[ARM_HUMIDITY]) begin
          res_nxt.humidity_alert  = hum_code;
          armed_nxt[ARM_HUMIDITY] = 1'b0;
        end
        if (temp_code == ALERT_NONE) begin
          armed_nxt[ARM_TEMP] = 1'b1;
        end else if (armed_r[ARM_TEMP]) begin
          res_nxt.temperature_alert = temp_code;
          armed_nxt[ARM_TEMP]       = 1'b0;
        end
      end
      KIND_SMOKE: begin
        res_nxt.detected = det;
      end
      default: ;
    endcase

    if (known) begin
      // a first frame only seeds the store and never logs
      res_nxt.log_record = !first_r[kidx] &&
                           ((prev_addr_r[kidx] != cur_addr) ||
                            (prev_ctrl_r[kidx] != cur_ctrl) ||
                            (prev_pay_r[kidx]  != s1_data_r.payload));
      first_nxt[kidx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= '1;
      armed_r     <= '1;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (move) begin
        first_r <= first_nxt;
        armed_r <= armed_nxt;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

  // payload registers and stored frames
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_data_r <= in_bus.data;
    end
    if (move) begin
      out_data_r <= res_nxt;
      if (known) begin
        prev_addr_r[kidx] <= cur_addr;
        prev_ctrl_r[kidx] <= cur_ctrl;
        prev_pay_r[kidx]  <= s1_data_r.payload;
      end
    end
  end

`ifndef ASSERT_OFF
  a_intruder_only_presence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.intruder_alert |->
      (out_data_r.sensor_kind == KIND_PRESENCE) && out_data_r.detected)
    else $error("intruder alert on a frame without presence detection");

  a_log_known_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.log_record |-> (out_data_r.sensor_kind != KIND_UNKNOWN))
    else $error("log record flagged for an unknown sensor type");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_valid_r && out_valid_r && !out_bus.ready)
    else $error("input stalled while the pipeline has room");

  a_hum_latch_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (out_data_r.humidity_alert == ALERT_NONE) || !armed_r[ARM_HUMIDITY])
    else $error("humidity latch still armed after firing");

  a_own_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    move && (kind == KIND_CLIMATE) |=> (cnt_r[KIND_CLIMATE] == 8'd0) && !first_r[KIND_CLIMATE])
    else $error("climate frame did not clear its silence count");
`endif

endmodule

// ===== dv/sensor_frame_alarm_monitor_top_test.sv =====
// Self-checking testbench for the sensor frame alarm monitor: frames in, one checked result out.
`timescale 1ns / 1ps

module sensor_frame_alarm_monitor_top_test;
  import sfam_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  sfam_frame_if  in_if ();
  sfam_result_if out_if ();
  sfam_cfg_if    cfg_if ();

  sensor_frame_alarm_monitor_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #1 clk = ~clk;

  // Register mirror
  logic [15:0] hum_high   = HUM_HIGH_RST;
  logic [15:0] hum_low    = HUM_LOW_RST;
  logic [15:0] temp_high  = TEMP_HIGH_RST;
  logic [15:0] temp_low   = TEMP_LOW_RST;
  logic [7:0]  quiet_max  = SILENCE_RST;
  logic        guard_on   = 1'b0;

  // Per-class state mirror
  logic [7:0]  quiet_count  [NUM_CLASSES] = '{8'd0, 8'd0, 8'd0};
  logic        first_seen   [NUM_CLASSES] = '{1'b1, 1'b1, 1'b1};
  logic        armed        [NUM_CLASSES] = '{1'b1, 1'b1, 1'b1};
  logic [63:0] last_addr    [NUM_CLASSES];
  logic [55:0] last_ctrl    [NUM_CLASSES];
  logic [47:0] last_payload [NUM_CLASSES];

  // Stimulus generator memory: repeat a class's last frame now and then
  frame_t      recent_frame [NUM_CLASSES];
  bit          have_recent  [NUM_CLASSES] = '{1'b0, 1'b0, 1'b0};

  frame_t      frame_q [$];
  result_t     alarm_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  bit          hold_done      = 1'b0;
  bit          rx_hold        = 1'b0;
  int unsigned hold_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_beats   = 0;
  int unsigned cycle_count    = 0;
  result_t     alarm_now;

  function automatic kind_t kind_of(logic [7:0] stype);
    case (stype)
      TYPE_PRESENCE: return KIND_PRESENCE;
      TYPE_CLIMATE:  return KIND_CLIMATE;
      TYPE_SMOKE:    return KIND_SMOKE;
      default:       return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic alert_t climate_alert(int unsigned slot, logic [15:0] level,
                                           logic [15:0] hi, logic [15:0] lo);
    alert_t code;
    code = ALERT_NONE;
    if (level > hi) code = ALERT_HIGH;
    else if (level < lo) code = ALERT_LOW;
    if (code == ALERT_NONE) armed[slot] = 1'b1;
    else if (armed[slot]) armed[slot] = 1'b0;
    else code = ALERT_NONE;
    return code;
  endfunction

  function automatic result_t predict_alarm(frame_t f);
    result_t     r;
    kind_t       kind;
    logic [63:0] addrs;
    logic [55:0] ctrl;
    logic [2:0]  quiet;
    logic        det;
    r = '0;
    addrs = {f.node_address, f.root_address};
    ctrl = {f.net_flag, f.node_state, f.channel, f.port_number,
            f.sensor_type, f.sensor_index, f.command_seq};
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (quiet_count[i] != COUNT_MAX) quiet_count[i] = quiet_count[i] + 8'd1;
      quiet[i] = quiet_count[i] > quiet_max;
    end
    kind = kind_of(f.sensor_type);
    r.sensor_kind = kind;
    if (kind != KIND_UNKNOWN) begin
      quiet_count[kind] = 8'd0;
      // first frame of a class only seeds the store, so it never logs
      if (first_seen[kind]) begin
        last_addr[kind] = addrs;
        last_ctrl[kind] = ctrl;
        last_payload[kind] = f.payload;
        first_seen[kind] = 1'b0;
      end
      det = f.payload[7:0] == DETECT_FLAG;
      case (kind)
        KIND_PRESENCE: begin
          r.detected = det;
          if (!det) armed[ARM_INTRUDER] = 1'b1;
          else if (guard_on && armed[ARM_INTRUDER]) begin
            r.intruder_alert = 1'b1;
            armed[ARM_INTRUDER] = 1'b0;
          end
        end
        KIND_CLIMATE: begin
          r.humidity_tenths = f.payload[31:16];
          r.temperature_tenths = f.payload[15:0];
          r.humidity_alert = climate_alert(ARM_HUMIDITY, f.payload[31:16], hum_high, hum_low);
          r.temperature_alert = climate_alert(ARM_TEMP, f.payload[15:0], temp_high, temp_low);
        end
        default: r.detected = det;
      endcase
      if (last_addr[kind] != addrs || last_ctrl[kind] != ctrl ||
          last_payload[kind] != f.payload) begin
        r.log_record = 1'b1;
        last_addr[kind] = addrs;
        last_ctrl[kind] = ctrl;
        last_payload[kind] = f.payload;
      end
    end
    r.climate_silent = quiet[KIND_CLIMATE];
    r.presence_silent = quiet[KIND_PRESENCE];
    r.smoke_silent = quiet[KIND_SMOKE];
    return r;
  endfunction

  // Mostly around the limits, sometimes anywhere in the 16-bit range
  function automatic logic [15:0] pick_level(logic [15:0] hi, logic [15:0] lo);
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'($urandom);
      1:       v = hi;
      2:       v = hi + 16'd1;
      3:       v = lo;
      4:       v = lo - 16'd1;
      default: v = 16'($urandom_range(hi, lo));
    endcase
    return v;
  endfunction

  function automatic frame_t make_frame(bit allow_smoke);
    frame_t      f;
    kind_t       kind;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) f.sensor_type = TYPE_PRESENCE;
    else if (pick < 60) f.sensor_type = TYPE_CLIMATE;
    else if (pick < 80 && allow_smoke) f.sensor_type = TYPE_SMOKE;
    else begin
      f.sensor_type = 8'($urandom_range(0, 255));
      if (!allow_smoke && f.sensor_type == TYPE_SMOKE) f.sensor_type = 8'hFF;
    end
    kind = kind_of(f.sensor_type);
    if (kind != KIND_UNKNOWN && have_recent[kind] && $urandom_range(0, 99) < 35)
      return recent_frame[kind];
    f.net_flag = 8'($urandom);
    f.node_address = $urandom;
    f.root_address = $urandom;
    f.node_state = 8'($urandom);
    f.channel = 8'($urandom);
    f.port_number = 8'($urandom);
    f.sensor_index = 8'($urandom);
    f.command_seq = 8'($urandom);
    f.payload[47:32] = 16'($urandom);
    f.payload[31:0] = $urandom;
    if (kind == KIND_CLIMATE) begin
      f.payload[31:16] = pick_level(hum_high, hum_low);
      f.payload[15:0] = pick_level(temp_high, temp_low);
    end else if (kind != KIND_UNKNOWN && $urandom_range(0, 1) == 1) begin
      f.payload[7:0] = DETECT_FLAG;
    end
    if (kind != KIND_UNKNOWN) begin
      recent_frame[kind] = f;
      have_recent[kind] = 1'b1;
    end
    return f;
  endfunction

  function automatic frame_t frame_of(logic [7:0] stype, logic [47:0] pay);
    frame_t f;
    f = '0;
    f.sensor_type = stype;
    f.payload = pay;
    return f;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("result %0d: %s expected %0d, got %0d", result_beats, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_wr_t w;
    w.index = idx;
    w.wdata = val;
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_HUM_HIGH:  hum_high = val;
      CFG_HUM_LOW:   hum_low = val;
      CFG_TEMP_HIGH: temp_high = val;
      CFG_TEMP_LOW:  temp_low = val;
      CFG_SILENCE:   quiet_max = val[7:0];
      CFG_GUARD:     guard_on = val[0];
      default:       ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] hh, logic [15:0] hl, logic [15:0] th,
                              logic [15:0] tl, logic [15:0] sil, logic [15:0] guard);
    write_reg(CFG_HUM_HIGH, hh);
    write_reg(CFG_HUM_LOW, hl);
    write_reg(CFG_TEMP_HIGH, th);
    write_reg(CFG_TEMP_LOW, tl);
    write_reg(CFG_SILENCE, sil);
    write_reg(CFG_GUARD, guard);
  endtask

  task automatic program_random_regs();
    program_regs(16'($urandom_range(300, 1000)), 16'($urandom_range(0, 400)),
                 16'($urandom_range(200, 800)), 16'($urandom_range(0, 300)),
                 16'($urandom_range(0, 40)), 16'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_if.valid || alarm_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned count, int unsigned send_pct, int unsigned recv_pct,
                           bit allow_smoke);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) frame_q.push_back(make_frame(allow_smoke));
    wait_drained();
  endtask

  // Frame driver: hold the beat until accepted, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) alarm_q.push_back(predict_alarm(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (frame_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.data <= frame_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (alarm_q.size() == 0) begin
        if (mismatch_count < 10) $display("result %0d arrived with no frame pending", result_beats);
        mismatch_count++;
      end else begin
        alarm_now = alarm_q.pop_front();
        check_field("sensor_kind", 16'(alarm_now.sensor_kind),
                    16'(out_if.data.sensor_kind));
        check_field("detected", 16'(alarm_now.detected), 16'(out_if.data.detected));
        check_field("humidity_tenths", alarm_now.humidity_tenths, out_if.data.humidity_tenths);
        check_field("temperature_tenths", alarm_now.temperature_tenths,
                    out_if.data.temperature_tenths);
        check_field("humidity_alert", 16'(alarm_now.humidity_alert),
                    16'(out_if.data.humidity_alert));
        check_field("temperature_alert", 16'(alarm_now.temperature_alert),
                    16'(out_if.data.temperature_alert));
        check_field("intruder_alert", 16'(alarm_now.intruder_alert),
                    16'(out_if.data.intruder_alert));
        check_field("log_record", 16'(alarm_now.log_record), 16'(out_if.data.log_record));
        check_field("climate_silent", 16'(alarm_now.climate_silent),
                    16'(out_if.data.climate_silent));
        check_field("presence_silent", 16'(alarm_now.presence_silent),
                    16'(out_if.data.presence_silent));
        check_field("smoke_silent", 16'(alarm_now.smoke_silent),
                    16'(out_if.data.smoke_silent));
      end
      result_beats++;
    end
    out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off, once requested
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      if (hold_count == HOLD_CYCLES) begin
        rx_hold <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        rx_hold <= 1'b1;
        hold_count <= hold_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: first frames, repeats, one-shot climate latches, unknown codes
    frame_q.push_back(frame_of(TYPE_PRESENCE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_PRESENCE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_PRESENCE, 48'hFFFF_FFFF_FFFE));
    frame_q[$].net_flag = 8'hFF;
    frame_q[$].node_address = 32'hFFFF_FFFF;
    frame_q[$].root_address = 32'hFFFF_FFFF;
    frame_q[$].node_state = 8'hFF;
    frame_q[$].channel = 8'hFF;
    frame_q[$].port_number = 8'hFF;
    frame_q[$].sensor_index = 8'hFF;
    frame_q[$].command_seq = 8'hFF;
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd700, 16'd400}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd800, 16'd500}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd200, 16'd100}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd500, 16'd100}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd100, 16'd0}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, 48'hFFFF_FFFF_FFFF));
    frame_q.push_back(frame_of(TYPE_SMOKE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_SMOKE, 48'h0000_0000_0100));
    frame_q.push_back(frame_of(8'h00, 48'hFFFF_FFFF_FFFF));
    frame_q.push_back(frame_of(8'hFF, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_PRESENCE - 8'd1, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_SMOKE + 8'd1, {16'd0, 16'd900, 16'd900}));
    wait_drained();

    // Masked writes, dropped indexes, guard mode on and a nonzero low limit
    write_reg(CFG_GUARD, 16'hFFFF);
    write_reg(CFG_TEMP_LOW, 16'd100);
    write_reg(CFG_HUM_LOW, 16'd0);
    write_reg(CFG_SILENCE, 16'hFF00);
    write_reg(cfg_idx_t'(CFG_IDX_SPARE_LO), 16'h1234);
    write_reg(cfg_idx_t'(CFG_IDX_SPARE_HI), 16'hFFFF);
    frame_q.push_back(frame_of(TYPE_PRESENCE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_PRESENCE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_PRESENCE, 48'd0));
    frame_q.push_back(frame_of(TYPE_PRESENCE, {40'd0, DETECT_FLAG}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd300, 16'd200}));
    frame_q.push_back(frame_of(TYPE_CLIMATE, {16'd0, 16'd0, 16'd50}));
    frame_q.push_back(frame_of(TYPE_SMOKE, {40'd0, DETECT_FLAG}));
    wait_drained();

    program_regs(HUM_HIGH_RST, HUM_LOW_RST, TEMP_HIGH_RST, TEMP_LOW_RST, 16'(SILENCE_RST),
                 16'd0);
    run_phase(250, 0, 0, 1'b1);

    // Every humidity value reads high or low; every class silent after one frame
    program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1);
    run_phase(250, 70, 0, 1'b1);

    // No smoke frames: let the smoke count saturate past the top limit
    program_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd254, 16'd0);
    run_phase(300, 0, 70, 1'b0);

    program_random_regs();
    run_phase(250, 25, 25, 1'b1);

    // Back-pressure: receiver holds off while the sender keeps offering
    program_random_regs();
    hold_request = 1'b1;
    run_phase(100, 0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alarm_q.size() != 0) begin
      $display("%0d results never arrived", alarm_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
